@@ rtl/hsvrgb_pkg.sv @@
// shared widths, constants and sextant codes for the hsv to rgb converter
package hsvrgb_pkg;

	// field widths
	localparam int HUE_W     = 16;
	localparam int CH_W      = 8;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 24;

	// hue geometry in 1/64 degree units
	localparam int HUE_TURN  = 23040;
	localparam int SEXT_SPAN = 3840;
	localparam int HUE_IDX_W = 15;
	localparam int REM_W     = 12;
	localparam int SEXT_W    = 3;

	// fixed point scales
	localparam int FULL_SCALE = 255;
	localparam int FRAC_SCALE = FULL_SCALE * SEXT_SPAN;
	localparam int PV_W   = 16;
	localparam int PROD_W = 20;
	localparam int Y_W    = 28;
	localparam int Y_SHIFT = 8;

	// divide by 979200 done as drop 8 bits, then divide by 3825
	localparam int QT_DIV   = FRAC_SCALE / (1 << Y_SHIFT);
	localparam int QT_IN_W  = Y_W - Y_SHIFT;
	localparam int QT_RECIP = 274;
	localparam int QT_SHIFT = 20;

	// divide by 255
	localparam int P_RECIP = 257;
	localparam int P_SHIFT = 16;

	// sextant codes
	localparam logic [SEXT_W-1:0] SEXT_RED_YEL = 3'd0;
	localparam logic [SEXT_W-1:0] SEXT_YEL_GRN = 3'd1;
	localparam logic [SEXT_W-1:0] SEXT_GRN_CYN = 3'd2;
	localparam logic [SEXT_W-1:0] SEXT_CYN_BLU = 3'd3;
	localparam logic [SEXT_W-1:0] SEXT_BLU_MAG = 3'd4;
	localparam logic [SEXT_W-1:0] SEXT_MAG_RED = 3'd5;

endpackage

@@ rtl/hsvrgb_cdiv.sv @@
// divide by a constant: reciprocal estimate in one stage, one-step correction after it
module hsvrgb_cdiv #(
	parameter int IN_W    = 20,
	parameter int DIVISOR = 3825,
	parameter int RECIP   = 274,
	parameter int SHIFT   = 20
) (
	input  logic                          clk,
	input  logic                          en_s4,
	input  logic [IN_W-1:0]               dividend,
	output logic [hsvrgb_pkg::CH_W-1:0]   quotient
);
	import hsvrgb_pkg::*;

	localparam int RW = $clog2(RECIP + 1);

	logic [IN_W+RW-1:0] prod;
	logic [IN_W-1:0]    num_s4;
	logic [CH_W-1:0]    est_s4;
	logic [IN_W-1:0]    back;
	logic [IN_W-1:0]    rem;

	// estimate never exceeds the true quotient and is at most one short
	assign prod = (IN_W+RW)'(dividend) * (IN_W+RW)'(RECIP);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			num_s4 <= dividend;
			est_s4 <= prod[SHIFT+CH_W-1:SHIFT];
		end
	end

	// remainder check and correction
	assign back = IN_W'(est_s4) * IN_W'(DIVISOR);
	assign rem  = num_s4 - back;
	assign quotient = (rem >= IN_W'(DIVISOR)) ? est_s4 + CH_W'(1) : est_s4;

endmodule

@@ rtl/hsv_to_rgb_convert.sv @@
// Converts one HSV pixel per clock to 8-bit RGB while the output side keeps up.
// Hue is in 1/64 degree units (hue of 23040 or more reads as zero), saturation
// and value are 8-bit fractions where 255 means 1.0; each channel is the exact
// value truncated toward zero. The block is a five-stage pipeline: sextant split,
// three products, the products scaled by value, a reciprocal estimate of the
// constant divisions, then correction and channel routing into the output
// register. An input transaction loads stage one; its valid flag passes through
// stages two to four and output valid is the stage-five flag. One pixel is taken
// every cycle while the output side keeps up, since every stage is a full
// pipeline register; each stage holds when the one after it is full and stalled,
// and empty stages keep filling during an output stall.
module hsv_to_rgb_convert (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// hue[15:0], saturation[23:16], brightness[31:24]
	input  logic [hsvrgb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// red[7:0], green[15:8], blue[23:16]
	output logic [hsvrgb_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import hsvrgb_pkg::*;

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	logic [HUE_W-1:0]     hue;
	logic [CH_W-1:0]      sat;
	logic [CH_W-1:0]      val;
	logic [HUE_IDX_W-1:0] hue_ok;
	logic [SEXT_W-1:0]    sext;
	logic [REM_W-1:0]     rem;

	logic [SEXT_W-1:0] sext_s1, sext_s2, sext_s3, sext_s4;
	logic [REM_W-1:0]  rem_s1;
	logic [CH_W-1:0]   sat_s1;
	logic [CH_W-1:0]   val_s1, val_s2, val_s3, val_s4;
	logic [PROD_W-1:0] sr_s2, st_s2;
	logic [PV_W-1:0]   pv_s2, pv_s3;
	logic [Y_W-1:0]    yq_s3, yt_s3;
	logic [CH_W-1:0]   p_ch, q_ch, t_ch;
	logic [CH_W-1:0]   red_s5, green_s5, blue_s5;
	logic [CH_W-1:0]   red, green, blue;

	// stage handshake: a stage moves when it is empty or its successor moves
	assign adv5 = !v5_s5 || m_axis_tready;
	assign adv4 = !v4_s4 || adv5;
	assign adv3 = !v3_s3 || adv4;
	assign adv2 = !v2_s2 || adv3;
	assign adv1 = !v1_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (adv1) v1_s1 <= s_axis_tvalid;
			if (adv2) v2_s2 <= v1_s1;
			if (adv3) v3_s3 <= v2_s2;
			if (adv4) v4_s4 <= v3_s3;
			if (adv5) v5_s5 <= v4_s4;
		end
	end

	// unpack input transaction
	assign hue = s_axis_tdata[HUE_W-1:0];
	assign sat = s_axis_tdata[HUE_W+CH_W-1:HUE_W];
	assign val = s_axis_tdata[HUE_W+2*CH_W-1:HUE_W+CH_W];

	// out-of-range hue wraps to zero, then split into sextant and remainder
	always_comb begin
		hue_ok = (hue < HUE_W'(HUE_TURN)) ? hue[HUE_IDX_W-1:0] : '0;
		sext = SEXT_RED_YEL;
		for (int k = 1; k < 6; k++) begin
			if (hue_ok >= HUE_IDX_W'(k * SEXT_SPAN)) sext = SEXT_W'(k);
		end
		rem = REM_W'(hue_ok - HUE_IDX_W'(sext) * HUE_IDX_W'(SEXT_SPAN));
	end

	// stage 1: sextant split
	always_ff @(posedge clk) begin
		if (adv1) begin
			sext_s1 <= sext;
			rem_s1  <= rem;
			sat_s1  <= sat;
			val_s1  <= val;
		end
	end

	// stage 2: saturation times fraction and its complement, value times (1-s)
	always_ff @(posedge clk) begin
		if (adv2) begin
			sext_s2 <= sext_s1;
			val_s2  <= val_s1;
			sr_s2   <= PROD_W'(sat_s1) * PROD_W'(rem_s1);
			st_s2   <= PROD_W'(sat_s1) * (PROD_W'(SEXT_SPAN) - PROD_W'(rem_s1));
			pv_s2   <= PV_W'(val_s1) * (PV_W'(FULL_SCALE) - PV_W'(sat_s1));
		end
	end

	// stage 3: scale the q and t numerators by value
	always_ff @(posedge clk) begin
		if (adv3) begin
			sext_s3 <= sext_s2;
			val_s3  <= val_s2;
			pv_s3   <= pv_s2;
			yq_s3   <= Y_W'(val_s2) * Y_W'(PROD_W'(FRAC_SCALE) - sr_s2);
			yt_s3   <= Y_W'(val_s2) * Y_W'(PROD_W'(FRAC_SCALE) - st_s2);
		end
	end

	// stage 4: reciprocal estimates, corrected combinationally after the register
	always_ff @(posedge clk) begin
		if (adv4) begin
			sext_s4 <= sext_s3;
			val_s4  <= val_s3;
		end
	end

	hsvrgb_cdiv #(
		.IN_W    (QT_IN_W),
		.DIVISOR (QT_DIV),
		.RECIP   (QT_RECIP),
		.SHIFT   (QT_SHIFT)
	) u_div_q (
		.clk      (clk),
		.en_s4    (adv4),
		.dividend (yq_s3[Y_W-1:Y_SHIFT]),
		.quotient (q_ch)
	);

	hsvrgb_cdiv #(
		.IN_W    (QT_IN_W),
		.DIVISOR (QT_DIV),
		.RECIP   (QT_RECIP),
		.SHIFT   (QT_SHIFT)
	) u_div_t (
		.clk      (clk),
		.en_s4    (adv4),
		.dividend (yt_s3[Y_W-1:Y_SHIFT]),
		.quotient (t_ch)
	);

	hsvrgb_cdiv #(
		.IN_W    (PV_W),
		.DIVISOR (FULL_SCALE),
		.RECIP   (P_RECIP),
		.SHIFT   (P_SHIFT)
	) u_div_p (
		.clk      (clk),
		.en_s4    (adv4),
		.dividend (pv_s3),
		.quotient (p_ch)
	);

	// route p, q, t and value by sextant; zero saturation yields grey on its own
	always_comb begin
		case (sext_s4)
			SEXT_RED_YEL: begin red = val_s4; green = t_ch;   blue = p_ch;   end
			SEXT_YEL_GRN: begin red = q_ch;   green = val_s4; blue = p_ch;   end
			SEXT_GRN_CYN: begin red = p_ch;   green = val_s4; blue = t_ch;   end
			SEXT_CYN_BLU: begin red = p_ch;   green = q_ch;   blue = val_s4; end
			SEXT_BLU_MAG: begin red = t_ch;   green = p_ch;   blue = val_s4; end
			default:      begin red = val_s4; green = p_ch;   blue = q_ch;   end
		endcase
	end

	// stage 5: output register
	always_ff @(posedge clk) begin
		if (adv5) begin
			red_s5   <= red;
			green_s5 <= green;
			blue_s5  <= blue;
		end
	end

	assign m_axis_tvalid = v5_s5;
	assign m_axis_tdata  = {blue_s5, green_s5, red_s5};

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the hsv to rgb pixel converter
module testbench;
	import hsvrgb_pkg::*;

	// one rgb pixel laid out as on m_axis_tdata
	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SHOW_LIMIT  = 10;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_valid = 1'b0;
	logic                  s_ready;
	logic [IN_DATA_W-1:0]  s_data = '0;
	logic                  m_valid;
	logic                  m_ready = 1'b0;
	logic [OUT_DATA_W-1:0] m_data;

	rgb_t expected_pixels[$];
	int   mismatch_count = 0;
	int   cycle_count = 0;
	int   stall_left = 0;
	bit   free_run = 1'b0;

	hsv_to_rgb_convert DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data)
	);

	// clock, period 12
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// exact truncated rgb of one hsv pixel
	function automatic rgb_t predict_rgb(input logic [HUE_W-1:0] hue,
			input logic [CH_W-1:0] sat, input logic [CH_W-1:0] bri);
		int unsigned     h;
		int unsigned     s;
		int unsigned     v;
		int unsigned     rem;
		int unsigned     p;
		int unsigned     q;
		int unsigned     t;
		logic [SEXT_W-1:0] sext;
		rgb_t            px;
		h = hue;
		s = sat;
		v = bri;
		if (h >= HUE_TURN) begin
			h = 0;
		end
		if (s == 0) begin
			px.red   = v[CH_W-1:0];
			px.green = v[CH_W-1:0];
			px.blue  = v[CH_W-1:0];
		end else begin
			sext = SEXT_W'(h / SEXT_SPAN);
			rem  = h % SEXT_SPAN;
			p = (v * (FULL_SCALE - s)) / FULL_SCALE;
			q = (v * (FRAC_SCALE - s * rem)) / FRAC_SCALE;
			t = (v * (FRAC_SCALE - s * (SEXT_SPAN - rem))) / FRAC_SCALE;
			case (sext)
				SEXT_RED_YEL: begin
					px.red = v[7:0]; px.green = t[7:0]; px.blue = p[7:0];
				end
				SEXT_YEL_GRN: begin
					px.red = q[7:0]; px.green = v[7:0]; px.blue = p[7:0];
				end
				SEXT_GRN_CYN: begin
					px.red = p[7:0]; px.green = v[7:0]; px.blue = t[7:0];
				end
				SEXT_CYN_BLU: begin
					px.red = p[7:0]; px.green = q[7:0]; px.blue = v[7:0];
				end
				SEXT_BLU_MAG: begin
					px.red = t[7:0]; px.green = p[7:0]; px.blue = v[7:0];
				end
				default: begin
					px.red = v[7:0]; px.green = p[7:0]; px.blue = q[7:0];
				end
			endcase
		end
		return px;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// hue: mostly in range, some near sextant edges, some anywhere in 16 bits
	function automatic logic [HUE_W-1:0] rand_hue();
		int roll;
		int edge_hue;
		roll = $urandom_range(0, 9);
		if (roll < 2) begin
			return HUE_W'($urandom);
		end else if (roll < 4) begin
			edge_hue = $urandom_range(0, 6) * SEXT_SPAN + $urandom_range(0, 4) - 2;
			if (edge_hue < 0)
				edge_hue = 0;
			return HUE_W'(edge_hue);
		end else begin
			return HUE_W'($urandom_range(0, HUE_TURN - 1));
		end
	endfunction

	function automatic logic [CH_W-1:0] rand_channel();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		else if (roll == 1)
			return '1;
		else
			return CH_W'($urandom);
	endfunction

	// present one pixel, wait for its transaction, then maybe idle
	task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [CH_W-1:0] sat,
			input logic [CH_W-1:0] bri);
		int gap;
		s_valid <= 1'b1;
		s_data  <= {bri, sat, hue};
		do @(posedge clk); while (!s_ready);
		expected_pixels.insert(expected_pixels.size(), predict_rgb(hue, sat, bri));
		gap = free_run ? 0 : pick_gap();
		if (gap > 0) begin
			s_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait until every expected pixel has come out
	task automatic wait_drained();
		s_valid <= 1'b0;
		do @(posedge clk); while (expected_pixels.size() != 0);
	endtask

	task automatic test_corners();
		send_pixel(16'd0,     8'd255, 8'd255);
		send_pixel(16'd0,     8'd0,   8'd0);
		send_pixel(16'd0,     8'd0,   8'd255);
		send_pixel(16'd12345, 8'd0,   8'd128);
		send_pixel(16'd3839,  8'd255, 8'd255);
		send_pixel(16'd3840,  8'd255, 8'd255);
		send_pixel(16'd7679,  8'd255, 8'd255);
		send_pixel(16'd7680,  8'd255, 8'd255);
		send_pixel(16'd11520, 8'd255, 8'd255);
		send_pixel(16'd15360, 8'd255, 8'd255);
		send_pixel(16'd19200, 8'd255, 8'd255);
		send_pixel(16'd23039, 8'd255, 8'd255);
		send_pixel(16'd23040, 8'd200, 8'd200);
		send_pixel(16'd65535, 8'd255, 8'd255);
		send_pixel(16'd30000, 8'd0,   8'd99);
		send_pixel(16'd1920,  8'd255, 8'd255);
		send_pixel(16'd5760,  8'd128, 8'd200);
		send_pixel(16'd9600,  8'd1,   8'd255);
		send_pixel(16'd13440, 8'd255, 8'd1);
		send_pixel(16'd17280, 8'd77,  8'd180);
		send_pixel(16'd21120, 8'd255, 8'd128);
		send_pixel(16'd0,     8'd255, 8'd0);
		send_pixel(16'd1,     8'd1,   8'd1);
		wait_drained();
	endtask

	task automatic test_random_stream(input int count);
		repeat (count) send_pixel(rand_hue(), rand_channel(), rand_channel());
	endtask

	// both sides always ready: full rate
	task automatic test_back_to_back(input int count);
		free_run = 1'b1;
		test_random_stream(count);
		wait_drained();
		free_run = 1'b0;
	endtask

	// short bursts with the pipeline emptied between them
	task automatic test_drain_pauses(input int bursts);
		repeat (bursts) begin
			test_random_stream($urandom_range(1, 12));
			wait_drained();
		end
	endtask

	// output side stalls at random, except in free-run stretches
	always @(posedge clk) begin
		if (free_run) begin
			m_ready <= 1'b1;
		end else if (stall_left > 0) begin
			m_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			m_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// compare each output transaction with the oldest expected pixel
	always @(posedge clk) begin : rgb_checker
		rgb_t got;
		rgb_t want;
		if (arst_n && m_valid && m_ready) begin
			got = m_data;
			if (expected_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOW_LIMIT)
					$display("unexpected pixel r=%0d g=%0d b=%0d", got.red, got.green,
						got.blue);
			end else begin
				want = expected_pixels.pop_front();
				if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_LIMIT)
						$display("mismatch: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							want.red, want.green, want.blue, got.red, got.green, got.blue);
				end
			end
		end
	end

	// run time guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_random_stream(600);
		test_drain_pauses(15);
		test_back_to_back(150);
		test_random_stream(150);
		wait_drained();
		repeat (12) @(posedge clk);
		if (mismatch_count == 0 && expected_pixels.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
